// File: src/barometric_sensor_compensation_macros.svh
//------------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent assertion forms for the port checker.
//------------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bsc port check failed");

// next-cycle implication
`define BSC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bsc port check failed");

`endif

// File: src/bsc_pkg.sv
//------------------------------------------------------------------------------
// Barometric compensation package
// Payload types, register indexes and arithmetic constants.
//------------------------------------------------------------------------------
package bsc_pkg;

	typedef logic [7:0] cfg_index_t;

	localparam cfg_index_t CFG_TEMP_TRIM       = 8'd0;
	localparam cfg_index_t CFG_PRESS_TRIM_LOW  = 8'd1;
	localparam cfg_index_t CFG_PRESS_TRIM_HIGH = 8'd2;
	localparam cfg_index_t CFG_PRESS_TRIM_NINE = 8'd3;

	localparam int FINE_OFFSET = 128000;
	localparam int PRESS_BASE  = 1048576;
	localparam int PRESS_SCALE = 3125;
	localparam int TEMP_ROUND  = 128;
	localparam int PRESS_MAX   = 262143;
	localparam int DIV_STEPS   = 64;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [17:0]        pressure_pa;
		logic               divide_fault;
	} result_t;

endpackage

// File: src/barometric_sensor_compensation.sv
//------------------------------------------------------------------------------
// Barometric sensor compensation
// Pipelined integer temperature and pressure compensation with trim registers.
//------------------------------------------------------------------------------
// channel  | signals                                   | dir
// sample   | sample_valid, sample_ready, sample        | in
// result   | result_valid, result_ready, result        | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One sample transfer per cycle while the output register is empty or taken.
// The pipeline holds the 64-stage radix-2 pressure divider plus 16 arithmetic
// stages. The whole pipeline advances together when the output register is
// empty or taken, so a result stall holds every stage in place.
// Reset clears valid bits and trim registers; cfg_ready is always high.
//------------------------------------------------------------------------------
module barometric_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  bsc_pkg::sample_t    sample,
	output logic                result_valid,
	input  logic                result_ready,
	output bsc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  bsc_pkg::cfg_index_t cfg_index,
	input  logic [63:0]         cfg_data
);

	localparam int NS = bsc_pkg::DIV_STEPS;

	logic [47:0]        temp_trim_q;
	logic [63:0]        press_trim_low_q;
	logic [63:0]        press_trim_high_q;
	logic signed [15:0] press_trim_nine_q;

	logic adv;

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8;

	assign t1 = temp_trim_q[15:0];
	assign t2 = $signed(temp_trim_q[31:16]);
	assign t3 = $signed(temp_trim_q[47:32]);
	assign p1 = press_trim_low_q[15:0];
	assign p2 = $signed(press_trim_low_q[31:16]);
	assign p3 = $signed(press_trim_low_q[47:32]);
	assign p4 = $signed(press_trim_low_q[63:48]);
	assign p5 = $signed(press_trim_high_q[15:0]);
	assign p6 = $signed(press_trim_high_q[31:16]);
	assign p7 = $signed(press_trim_high_q[47:32]);
	assign p8 = $signed(press_trim_high_q[63:48]);

	assign cfg_ready    = 1'b1;
	assign adv          = !result_valid || result_ready;
	assign sample_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q       <= '0;
			press_trim_low_q  <= '0;
			press_trim_high_q <= '0;
			press_trim_nine_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsc_pkg::CFG_TEMP_TRIM:       temp_trim_q       <= cfg_data[47:0];
				bsc_pkg::CFG_PRESS_TRIM_LOW:  press_trim_low_q  <= cfg_data;
				bsc_pkg::CFG_PRESS_TRIM_HIGH: press_trim_high_q <= cfg_data;
				bsc_pkg::CFG_PRESS_TRIM_NINE: press_trim_nine_q <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// valid bits, front stages s1..s9
	logic [9:1] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[8:1], sample_valid};
		end
	end

	// s1: temperature products
	logic signed [17:0] x1;
	logic signed [16:0] d1;
	logic signed [33:0] m1_s1, dd_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;

	assign x1 = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d1 = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1 <= x1 * t2;
			dd_s1 <= d1 * d1;
			rp_s1 <= sample.raw_pressure;
		end
	end

	// s2
	logic signed [22:0] a_s2;
	logic signed [37:0] bp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2  <= $signed(m1_s1[33:11]);
			bp_s2 <= $signed(dd_s1[33:12]) * t3;
			rp_s2 <= rp_s1;
		end
	end

	// s3: fine temperature
	logic signed [23:0] fine_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s3 <= 24'(a_s2) + $signed(bp_s2[37:14]);
			rp_s3   <= rp_s2;
		end
	end

	// s4: centidegrees and pressure offset
	logic signed [26:0] t5;
	logic signed [18:0] tw;
	logic signed [15:0] tsat;
	logic signed [24:0] pa_s4;
	logic signed [15:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9;

	assign t5 = 27'(fine_s3) * 27'sd5 + 27'(bsc_pkg::TEMP_ROUND);
	assign tw = $signed(t5[26:8]);

	always_comb begin
		if (tw > 19'sd32767) begin
			tsat = 16'sh7fff;
		end else if (tw < -19'sd32768) begin
			tsat = 16'sh8000;
		end else begin
			tsat = tw[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s4 <= 25'(fine_s3) - 25'(bsc_pkg::FINE_OFFSET);
			tc_s4 <= tsat;
			rp_s4 <= rp_s3;
		end
	end

	// s5
	logic signed [49:0] aa_s5;
	logic signed [40:0] ap5_s5, ap2_s5, ap5_s6, ap2_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_s5  <= pa_s4 * pa_s4;
			ap5_s5 <= pa_s4 * p5;
			ap2_s5 <= pa_s4 * p2;
			tc_s5  <= tc_s4;
			rp_s5  <= rp_s4;
		end
	end

	// s6
	logic signed [63:0] aap6_s6, aap3_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			aap6_s6 <= 64'(aa_s5) * 64'(p6);
			aap3_s6 <= 64'(aa_s5) * 64'(p3);
			ap5_s6  <= ap5_s5;
			ap2_s6  <= ap2_s5;
			tc_s6   <= tc_s5;
			rp_s6   <= rp_s5;
		end
	end

	// s7
	logic [63:0] b_s7, a_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s7  <= aap6_s6 + (64'(ap5_s6) << 17) + (64'(p4) << 35);
			a_s7  <= (aap3_s6 >>> 8) + (64'(ap2_s6) << 12);
			tc_s7 <= tc_s6;
			rp_s7 <= rp_s6;
		end
	end

	// s8
	logic [20:0] pd;
	logic [63:0] v_s8, num0_s8;

	assign pd = 21'(bsc_pkg::PRESS_BASE) - {1'b0, rp_s7};

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s8    <= (a_s7 + {16'h0000, 1'b1, 47'd0}) * {48'd0, p1};
			num0_s8 <= {12'd0, pd, 31'd0} - b_s7;
			tc_s8   <= tc_s7;
		end
	end

	// s9
	logic signed [30:0] div_s9;
	logic [63:0]        num_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s9 <= $signed(v_s8[63:33]);
			num_s9 <= num0_s8 * 64'(bsc_pkg::PRESS_SCALE);
			tc_s9  <= tc_s8;
		end
	end

	// divider: entry 0 is the magnitude stage, entries 1..NS one quotient bit each
	logic [30:0]        dv_rem_s [0:NS];
	logic [63:0]        dv_nq_s  [0:NS];
	logic [30:0]        dv_mb_s  [0:NS];
	logic               dv_neg_s [0:NS];
	logic               dv_flt_s [0:NS];
	logic signed [15:0] dv_tc_s  [0:NS];
	logic [NS:0]        dv_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s <= '0;
		end else if (adv) begin
			dv_v_s <= {dv_v_s[NS-1:0], v_s[9]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0] <= '0;
			dv_nq_s[0]  <= num_s9[63] ? 64'd0 - num_s9 : num_s9;
			dv_mb_s[0]  <= div_s9[30] ? 31'd0 - $unsigned(div_s9) : $unsigned(div_s9);
			dv_neg_s[0] <= num_s9[63] ^ div_s9[30];
			dv_flt_s[0] <= (div_s9 == 31'sd0);
			dv_tc_s[0]  <= tc_s9;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [31:0] shifted;
		logic [32:0] trial;

		assign shifted = {dv_rem_s[k], dv_nq_s[k][63]};
		assign trial   = {1'b0, shifted} - {2'b00, dv_mb_s[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k+1] <= trial[32] ? shifted[30:0] : trial[30:0];
				dv_nq_s[k+1]  <= {dv_nq_s[k][62:0], !trial[32]};
				dv_mb_s[k+1]  <= dv_mb_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_flt_s[k+1] <= dv_flt_s[k];
				dv_tc_s[k+1]  <= dv_tc_s[k];
			end
		end
	end

	// back stages q1..q5
	logic [5:1]         v_q;
	logic [63:0]        p_q1, p_q2, p_q3, p_q4, slsl_q2, p8p_q2, sq_q3, b_q3, b_q4, a_q4;
	logic [63:0]        sum_q5;
	logic [31:0]        shsl_q2, sh_ext;
	logic signed [15:0] tc_q1, tc_q2, tc_q3, tc_q4, tc_q5;
	logic               flt_q1, flt_q2, flt_q3, flt_q4, flt_q5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[4:1], dv_v_s[NS]};
		end
	end

	assign sh_ext = {{13{p_q1[63]}}, p_q1[63:45]};

	always_ff @(posedge clk) begin
		if (adv) begin
			p_q1    <= dv_neg_s[NS] ? 64'd0 - dv_nq_s[NS] : dv_nq_s[NS];
			tc_q1   <= dv_tc_s[NS];
			flt_q1  <= dv_flt_s[NS];

			// square of p >>> 13, split at bit 32
			slsl_q2 <= {32'd0, p_q1[44:13]} * {32'd0, p_q1[44:13]};
			shsl_q2 <= sh_ext * p_q1[44:13];
			p8p_q2  <= p_q1 * {{48{p8[15]}}, p8};
			p_q2    <= p_q1;
			tc_q2   <= tc_q1;
			flt_q2  <= flt_q1;

			sq_q3   <= slsl_q2 + {shsl_q2[30:0], 33'd0};
			b_q3    <= {{19{p8p_q2[63]}}, p8p_q2[63:19]};
			p_q3    <= p_q2;
			tc_q3   <= tc_q2;
			flt_q3  <= flt_q2;

			a_q4    <= {{48{press_trim_nine_q[15]}}, press_trim_nine_q} * sq_q3;
			b_q4    <= b_q3;
			p_q4    <= p_q3;
			tc_q4   <= tc_q3;
			flt_q4  <= flt_q3;

			sum_q5  <= p_q4 + {{25{a_q4[63]}}, a_q4[63:25]} + b_q4;
			tc_q5   <= tc_q4;
			flt_q5  <= flt_q4;
		end
	end

	// output register
	logic [63:0] xo, yo;
	logic [17:0] psat;

	assign xo = {{8{sum_q5[63]}}, sum_q5[63:8]} + {{44{p7[15]}}, p7, 4'd0};
	assign yo = {{8{xo[63]}}, xo[63:8]};

	always_comb begin
		if (flt_q5 || yo[63]) begin
			psat = '0;
		end else if (yo > 64'(bsc_pkg::PRESS_MAX)) begin
			psat = 18'(bsc_pkg::PRESS_MAX);
		end else begin
			psat = yo[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= v_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.temperature_centi <= tc_q5;
			result.pressure_pa       <= psat;
			result.divide_fault      <= flt_q5;
		end
	end

endmodule

// File: src/bsc_checker.sv
//------------------------------------------------------------------------------
// Barometric compensation port checker
// Port-level checks bound to the top level.
//------------------------------------------------------------------------------
`include "barometric_sensor_compensation_macros.svh"

module bsc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_ready,
	input logic             result_valid,
	input logic             result_ready,
	input bsc_pkg::result_t result,
	input logic             cfg_ready
);

	`BSC_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`BSC_ASSERT_IMP(a_fault_zero, clk, arst_n, result_valid && result.divide_fault, result.pressure_pa == 18'd0)
	`BSC_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !result_valid, sample_ready)
	`BSC_ASSERT_IMP(a_cfg_ready, clk, arst_n, sample_valid || !sample_valid, cfg_ready)

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);

// File: tb/barometric_sensor_compensation_test.sv
//------------------------------------------------------------------------------
// Barometric sensor compensation testbench
// Streams raw pressure/temperature pairs through the block under several trim
// settings, predicts each compensated result in 64-bit arithmetic and checks
// every result transfer in order, with random gaps and stalls on both sides.
//------------------------------------------------------------------------------
module barometric_sensor_compensation_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 80;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	bsc_pkg::sample_t    sample = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	bsc_pkg::result_t    result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	bsc_pkg::cfg_index_t cfg_index = bsc_pkg::CFG_TEMP_TRIM;
	logic [63:0]         cfg_data = '0;

	logic [47:0] temp_trim;
	logic [63:0] press_trim_low;
	logic [63:0] press_trim_high;
	logic [15:0] press_trim_nine;

	bsc_pkg::sample_t pending_samples[$];
	bsc_pkg::result_t expected_results[$];
	int      errors = 0;
	int      checked = 0;
	int      faults_seen = 0;
	int      send_wait = 0;
	int      take_wait = 0;
	bit      hold_off = 1'b0;
	bit      gaps_on = 1'b1;

	barometric_sensor_compensation dut (.*);

	always #5 clk = ~clk;

	function automatic logic signed [63:0] sx(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic bsc_pkg::result_t compensate(input bsc_pkg::sample_t s);
		logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] a, b, d, fine, p, t, pt;
		logic signed [63:0] at, ap;
		bsc_pkg::result_t r;
		t1 = {48'd0, temp_trim[15:0]};
		t2 = sx(temp_trim[31:16]);
		t3 = sx(temp_trim[47:32]);
		p1 = {48'd0, press_trim_low[15:0]};
		p2 = sx(press_trim_low[31:16]);
		p3 = sx(press_trim_low[47:32]);
		p4 = sx(press_trim_low[63:48]);
		p5 = sx(press_trim_high[15:0]);
		p6 = sx(press_trim_high[31:16]);
		p7 = sx(press_trim_high[47:32]);
		p8 = sx(press_trim_high[63:48]);
		p9 = sx(press_trim_nine);
		at = {44'd0, s.raw_temperature};
		ap = {44'd0, s.raw_pressure};
		a = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (at >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		t = (fine * 5 + 128) >>> 8;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		r.temperature_centi = t[15:0];
		r.pressure_pa = '0;
		r.divide_fault = 1'b0;
		a = fine - 128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			r.divide_fault = 1'b1;
		end else begin
			p = 64'sd1048576 - ap;
			p = ((p <<< 31) - b) * 3125;
			if (a == -1)
				p = -p;
			else
				p = p / a;
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			pt = p >>> 8;
			if (pt < 0)
				r.pressure_pa = '0;
			else if (pt > 262143)
				r.pressure_pa = 18'h3FFFF;
			else
				r.pressure_pa = pt[17:0];
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			expected_results.push_back(compensate(sample));
		end
		if (sample_valid && !sample_ready) begin
		end else if (send_wait > 0) begin
			sample_valid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (!hold_off && pending_samples.size() > 0) begin
			sample_valid <= 1'b1;
			sample <= pending_samples.pop_front();
			send_wait <= gaps_on ? $urandom_range(0, 10) : 0;
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				bsc_pkg::result_t e;
				e = expected_results.pop_front();
				checked++;
				if (result.divide_fault)
					faults_seen++;
				if (result.temperature_centi !== e.temperature_centi) begin
					$display("%0t: temperature_centi expected %0d actual %0d", $time,
						e.temperature_centi, result.temperature_centi);
					errors++;
				end
				if (result.pressure_pa !== e.pressure_pa) begin
					$display("%0t: pressure_pa expected %0d actual %0d", $time,
						e.pressure_pa, result.pressure_pa);
					errors++;
				end
				if (result.divide_fault !== e.divide_fault) begin
					$display("%0t: divide_fault expected %0b actual %0b", $time,
						e.divide_fault, result.divide_fault);
					errors++;
				end
			end
		end
		if (!gaps_on || take_wait == 0) begin
			result_ready <= 1'b1;
			take_wait <= gaps_on ? $urandom_range(0, 10) : 0;
		end else begin
			result_ready <= 1'b0;
			take_wait <= take_wait - 1;
		end
	end

	task automatic write_reg(input bsc_pkg::cfg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bsc_pkg::CFG_TEMP_TRIM:       temp_trim = value[47:0];
			bsc_pkg::CFG_PRESS_TRIM_LOW:  press_trim_low = value;
			bsc_pkg::CFG_PRESS_TRIM_HIGH: press_trim_high = value;
			bsc_pkg::CFG_PRESS_TRIM_NINE: press_trim_nine = value[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic load_trims(input int kind);
		case (kind)
			0: begin
				write_reg(bsc_pkg::CFG_TEMP_TRIM,
					{16'h0000, 16'hFC18, 16'h6682, 16'h6D80});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_LOW,
					{16'h1C1A, 16'h0BD0, 16'hD673, 16'h8E42});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_HIGH,
					{16'hC0EE, 16'h0F8C, 16'hFFF9, 16'h008C});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_NINE, 64'h1770);
			end
			1: begin
				write_reg(bsc_pkg::CFG_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(bsc_pkg::CFG_PRESS_TRIM_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(bsc_pkg::CFG_PRESS_TRIM_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(bsc_pkg::CFG_PRESS_TRIM_NINE, 64'hFFFF);
			end
			2: begin
				write_reg(bsc_pkg::CFG_TEMP_TRIM,
					{16'h0000, 16'h8000, 16'h7FFF, 16'h0000});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_LOW,
					{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_HIGH,
					{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_NINE, 64'h8000);
			end
			default: begin
				write_reg(bsc_pkg::CFG_TEMP_TRIM, {$urandom, $urandom});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_LOW, {$urandom, $urandom});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_HIGH, {$urandom, $urandom});
				write_reg(bsc_pkg::CFG_PRESS_TRIM_NINE, {$urandom, $urandom});
			end
		endcase
	endtask

	function automatic bsc_pkg::sample_t pick_sample(input int kind);
		bsc_pkg::sample_t s;
		s.raw_pressure = 20'($urandom);
		s.raw_temperature = 20'($urandom);
		if (kind == 0) begin
			s.raw_pressure = 20'(415148 + $urandom_range(0, 8000) - 4000);
			s.raw_temperature = 20'(519888 + $urandom_range(0, 8000) - 4000);
		end
		return s;
	endfunction

	initial begin
		temp_trim = '0;
		press_trim_low = '0;
		press_trim_high = '0;
		press_trim_nine = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// zero trims: divisor zero on every sample
		pending_samples.push_back('{20'd0, 20'd0});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
		drain();
		for (int k = 0; k < 4; k++) begin
			load_trims(k);
			pending_samples.push_back('{20'd0, 20'd0});
			pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
			pending_samples.push_back('{20'd0, 20'hFFFFF});
			pending_samples.push_back('{20'hFFFFF, 20'd0});
			pending_samples.push_back('{20'd415148, 20'd519888});
			drain();
		end
		for (int phase = 0; phase < 6; phase++) begin
			load_trims(phase < 2 ? 0 : (phase == 5 ? 1 : 3));
			gaps_on = (phase != 2);
			for (int i = 0; i < 320; i++)
				pending_samples.push_back(pick_sample(phase == 0 ? 0 : i % 3));
			if (phase == 1) begin
				while (pending_samples.size() > 160)
					@(posedge clk);
				hold_off = 1'b1;
				while (sample_valid || expected_results.size() > 0)
					@(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end
		$display("Checked %0d results over several trim sets, %0d with divisor faults.",
			checked, faults_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3ms;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("DONE: errors detected");
		$finish;
	end
endmodule
